// ===== rtl/cpsat_pkg.sv =====
// Shared types and constants for the convex polygon SAT collision block.
// No dependencies; the other files that use it refer to this package by scoped names.
package cpsat_pkg;

  // Width of the coordinate fields on the input word
  localparam int FIELD_BITS = 16;

  // Polygon select codes
  localparam logic POLY_FIRST  = 1'b0;
  localparam logic POLY_SECOND = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic wr_en;     // store the incoming vertex
    logic wr_sel;    // polygon store to write
    logic rd_en;     // read one store entry
    logic rd_sel;    // polygon store to read
    logic rd_proj;   // the read feeds the projection pipe
    logic rd_first;  // first vertex of a polygon: restart its range
    logic cap_edge;  // latch the edge start vertex
    logic cap_axis;  // form the edge normal from start and end vertex
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic busy;      // projection pipe still holds vertices
    logic overlap;   // both ranges overlap strictly on the current axis
  } sts_t;

endpackage

// ===== rtl/cpsat_in_if.sv =====
// Vertex input channel: valid/ready handshake with one vertex per word.
// Depends on cpsat_pkg for the coordinate field width.
interface cpsat_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   kind;
  logic signed [cpsat_pkg::FIELD_BITS-1:0] vertex_x;
  logic signed [cpsat_pkg::FIELD_BITS-1:0] vertex_y;
  logic                                   last;

  modport source (output valid, kind, vertex_x, vertex_y, last, input ready);
  modport sink   (input valid, kind, vertex_x, vertex_y, last, output ready);
endinterface

// ===== rtl/cpsat_out_if.sv =====
// Result output channel: valid/ready handshake with one test result per word.
// No dependencies.
interface cpsat_out_if;
  logic valid;
  logic ready;
  logic colliding;
  logic overflow;

  modport source (output valid, colliding, overflow, input ready);
  modport sink   (input valid, colliding, overflow, output ready);
endinterface

// ===== rtl/convex_polygon_sat_collision.sv =====
// Top level of the 2D separating-axis collision test.
// Depends on cpsat_pkg, cpsat_in_if, cpsat_out_if, cpsat_ctrl and cpsat_dp.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    kind, vertex_x, vertex_y, last
//   out_ch    out  valid/ready    colliding, overflow
//
// A vertex word is taken on each handshake while loading. After the word with
// last set, the test runs from the single read port of the vertex stores: per
// axis an edge fetch, both polygons streamed through the projection pipe and a
// drain, over up to n1 + n2 axes; a separating axis ends it.
// Input is held off during the test; the result word waits in an output
// register, so loading of the next pair continues while it is not taken.
// Reset is synchronous, active low, and empties both polygons.
module convex_polygon_sat_collision #(
  parameter int MAX_VERTS  = 16,
  parameter int COORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  cpsat_in_if.sink           in_ch,
  cpsat_out_if.source        out_ch
);

  localparam int AW = $clog2(MAX_VERTS);

  cpsat_pkg::cmd_t cmd;
  cpsat_pkg::sts_t sts;
  logic [AW-1:0]   wr_addr, rd_addr;

  cpsat_ctrl #(
    .MAX_VERTS (MAX_VERTS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_kind       (in_ch.kind),
    .in_last       (in_ch.last),
    .in_ready      (in_ch.ready),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_colliding (out_ch.colliding),
    .out_overflow  (out_ch.overflow),
    .cmd           (cmd),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr),
    .sts           (sts)
  );

  cpsat_dp #(
    .MAX_VERTS  (MAX_VERTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_x    (in_ch.vertex_x),
    .in_y    (in_ch.vertex_y),
    .cmd     (cmd),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .sts     (sts)
  );

endmodule

// ===== rtl/cpsat_dp.sv =====
// Datapath: two vertex stores, edge normal former and a three-stage
// projection pipe (read, multiply, accumulate min/max). Uses cpsat_pkg.
module cpsat_dp #(
  parameter int MAX_VERTS  = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic signed [cpsat_pkg::FIELD_BITS-1:0] in_x,
  input  logic signed [cpsat_pkg::FIELD_BITS-1:0] in_y,
  input  cpsat_pkg::cmd_t                         cmd,
  input  logic [$clog2(MAX_VERTS)-1:0]            wr_addr,
  input  logic [$clog2(MAX_VERTS)-1:0]            rd_addr,
  output cpsat_pkg::sts_t                         sts
);

  localparam int CW  = COORD_BITS;
  localparam int AXW = COORD_BITS + 1;
  localparam int PW  = 2 * COORD_BITS + 1;
  localparam int QW  = 2 * COORD_BITS + 2;

  logic signed [CW-1:0] wr_x, wr_y;
  logic [2*CW-1:0]      mem0 [MAX_VERTS];
  logic [2*CW-1:0]      mem1 [MAX_VERTS];
  logic [2*CW-1:0]      rdata_r;
  logic signed [CW-1:0] rd_x, rd_y;
  logic                 rd_v_r, rd_first_r, rd_poly_r;
  logic signed [CW-1:0] ea_x_r, ea_y_r;
  logic signed [AXW-1:0] ax_r, ay_r;
  logic signed [PW-1:0] px_r, py_r;
  logic                 pv_r, pfirst_r, ppoly_r;
  logic signed [QW-1:0] q;
  logic signed [QW-1:0] lo0_r, hi0_r, lo1_r, hi1_r;

  // Take the low coordinate bits as two's complement; a wider COORD_BITS zero-extends
  if (COORD_BITS <= cpsat_pkg::FIELD_BITS) begin : g_trim
    assign wr_x = in_x[CW-1:0];
    assign wr_y = in_y[CW-1:0];
  end else begin : g_ext
    assign wr_x = {{(CW-cpsat_pkg::FIELD_BITS){1'b0}}, in_x};
    assign wr_y = {{(CW-cpsat_pkg::FIELD_BITS){1'b0}}, in_y};
  end

  // Write incoming vertices, read one entry per cycle while rd_en is set
  always_ff @(posedge clk) begin
    if (cmd.wr_en && cmd.wr_sel == cpsat_pkg::POLY_FIRST) begin
      mem0[wr_addr] <= {wr_y, wr_x};
    end
    if (cmd.wr_en && cmd.wr_sel == cpsat_pkg::POLY_SECOND) begin
      mem1[wr_addr] <= {wr_y, wr_x};
    end
    if (cmd.rd_en) begin
      rdata_r <= (cmd.rd_sel == cpsat_pkg::POLY_SECOND) ? mem1[rd_addr] : mem0[rd_addr];
    end
  end

  assign rd_x = rdata_r[CW-1:0];
  assign rd_y = rdata_r[2*CW-1:CW];

  // Pipe valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      pv_r   <= 1'b0;
    end else begin
      rd_v_r <= cmd.rd_en && cmd.rd_proj;
      pv_r   <= rd_v_r;
    end
  end

  // Edge normal (-dy, dx) and the multiply stage
  always_ff @(posedge clk) begin
    rd_first_r <= cmd.rd_first;
    rd_poly_r  <= cmd.rd_sel;
    if (cmd.cap_edge) begin
      ea_x_r <= rd_x;
      ea_y_r <= rd_y;
    end
    if (cmd.cap_axis) begin
      ax_r <= AXW'(ea_y_r) - AXW'(rd_y);
      ay_r <= AXW'(rd_x) - AXW'(ea_x_r);
    end
    px_r     <= rd_x * ax_r;
    py_r     <= rd_y * ay_r;
    pfirst_r <= rd_first_r;
    ppoly_r  <= rd_poly_r;
  end

  assign q = QW'(px_r) + QW'(py_r);

  // Accumulate the projected range of each polygon
  always_ff @(posedge clk) begin
    if (pv_r && ppoly_r == cpsat_pkg::POLY_FIRST) begin
      if (pfirst_r || q < lo0_r) lo0_r <= q;
      if (pfirst_r || q > hi0_r) hi0_r <= q;
    end
    if (pv_r && ppoly_r == cpsat_pkg::POLY_SECOND) begin
      if (pfirst_r || q < lo1_r) lo1_r <= q;
      if (pfirst_r || q > hi1_r) hi1_r <= q;
    end
  end

  assign sts = '{busy: rd_v_r | pv_r, overlap: (hi1_r > lo0_r) && (hi0_r > lo1_r)};

  // A new axis is formed only once the previous projections have drained
  a_axis_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_axis |-> !rd_v_r && !pv_r)
    else $error("axis changed while projections in flight");

endmodule

// ===== rtl/cpsat_ctrl.sv =====
// Controller: vertex counts, overflow flag, axis/vertex sequencing and the
// result register. Drives cpsat_dp through cpsat_pkg::cmd_t / sts_t.
module cpsat_ctrl #(
  parameter int MAX_VERTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_kind,
  input  logic                          in_last,
  output logic                          in_ready,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_colliding,
  output logic                          out_overflow,
  output cpsat_pkg::cmd_t               cmd,
  output logic [$clog2(MAX_VERTS)-1:0]  wr_addr,
  output logic [$clog2(MAX_VERTS)-1:0]  rd_addr,
  input  cpsat_pkg::sts_t               sts
);

  localparam int AW = $clog2(MAX_VERTS);
  localparam int CW = $clog2(MAX_VERTS + 1);

  typedef enum logic [2:0] {
    S_LOAD, S_START, S_EDGE_I, S_EDGE_J, S_AXIS, S_PROJ, S_DRAIN, S_RESULT
  } state_t;

  state_t        state_r;
  logic [CW-1:0] cnt0_r, cnt1_r;
  logic          ovf_r, col_r;
  logic          edge_poly_r, proj_poly_r;
  logic [AW-1:0] idx_r, k_r;
  logic          out_valid_r, colliding_r, overflow_r;

  logic          in_acc;
  logic [CW-1:0] cnt_sel, n_e, n_p;
  logic          room, i_last, k_last;
  logic [AW-1:0] j_addr;

  assign in_acc  = in_valid && in_ready;
  assign cnt_sel = (in_kind == cpsat_pkg::POLY_SECOND) ? cnt1_r : cnt0_r;
  assign room    = cnt_sel < CW'(MAX_VERTS);
  assign n_e     = (edge_poly_r == cpsat_pkg::POLY_SECOND) ? cnt1_r : cnt0_r;
  assign n_p     = (proj_poly_r == cpsat_pkg::POLY_SECOND) ? cnt1_r : cnt0_r;
  assign i_last  = (CW'(idx_r) + CW'(1)) == n_e;
  assign k_last  = (CW'(k_r) + CW'(1)) == n_p;
  assign j_addr  = i_last ? '0 : idx_r + AW'(1);

  // Commands to the datapath
  always_comb begin
    cmd          = '0;
    cmd.wr_en    = in_acc && room;
    cmd.wr_sel   = in_kind;
    cmd.rd_en    = (state_r == S_EDGE_I) || (state_r == S_EDGE_J) || (state_r == S_PROJ);
    cmd.rd_sel   = (state_r == S_PROJ) ? proj_poly_r : edge_poly_r;
    cmd.rd_proj  = state_r == S_PROJ;
    cmd.rd_first = k_r == '0;
    cmd.cap_edge = state_r == S_EDGE_J;
    cmd.cap_axis = state_r == S_AXIS;
    wr_addr      = cnt_sel[AW-1:0];
    unique case (state_r)
      S_EDGE_J: rd_addr = j_addr;
      S_PROJ:   rd_addr = k_r;
      default:  rd_addr = idx_r;
    endcase
  end

  assign in_ready      = state_r == S_LOAD;
  assign out_valid     = out_valid_r;
  assign out_colliding = colliding_r;
  assign out_overflow  = overflow_r;

  // State, counts and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt0_r      <= '0;
      cnt1_r      <= '0;
      ovf_r       <= 1'b0;
      col_r       <= 1'b0;
      edge_poly_r <= cpsat_pkg::POLY_FIRST;
      proj_poly_r <= cpsat_pkg::POLY_FIRST;
      idx_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      colliding_r <= 1'b0;
      overflow_r  <= 1'b0;
    end else begin
      // drop the result word once taken
      if (out_valid_r && out_ready && state_r != S_RESULT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (!room) ovf_r <= 1'b1;
            else if (in_kind == cpsat_pkg::POLY_SECOND) cnt1_r <= cnt1_r + CW'(1);
            else cnt0_r <= cnt0_r + CW'(1);
            if (in_last) state_r <= S_START;
          end
        end
        S_START: begin
          edge_poly_r <= cpsat_pkg::POLY_FIRST;
          idx_r       <= '0;
          if (cnt0_r == '0 && cnt1_r == '0) begin
            col_r   <= 1'b1;
            state_r <= S_RESULT;
          end else if (cnt0_r == '0 || cnt1_r == '0) begin
            col_r   <= 1'b0;
            state_r <= S_RESULT;
          end else begin
            state_r <= S_EDGE_I;
          end
        end
        S_EDGE_I: state_r <= S_EDGE_J;
        S_EDGE_J: state_r <= S_AXIS;
        S_AXIS: begin
          k_r         <= '0;
          proj_poly_r <= cpsat_pkg::POLY_FIRST;
          state_r     <= S_PROJ;
        end
        S_PROJ: begin
          // walk the first polygon, then the second
          if (k_last) begin
            k_r <= '0;
            if (proj_poly_r == cpsat_pkg::POLY_FIRST) proj_poly_r <= cpsat_pkg::POLY_SECOND;
            else state_r <= S_DRAIN;
          end else begin
            k_r <= k_r + AW'(1);
          end
        end
        S_DRAIN: begin
          if (!sts.busy) begin
            if (!sts.overlap) begin
              col_r   <= 1'b0;
              state_r <= S_RESULT;
            end else if (!i_last) begin
              idx_r   <= idx_r + AW'(1);
              state_r <= S_EDGE_I;
            end else if (edge_poly_r == cpsat_pkg::POLY_FIRST) begin
              edge_poly_r <= cpsat_pkg::POLY_SECOND;
              idx_r       <= '0;
              state_r     <= S_EDGE_I;
            end else begin
              col_r   <= 1'b1;
              state_r <= S_RESULT;
            end
          end
        end
        S_RESULT: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            colliding_r <= col_r;
            overflow_r  <= ovf_r;
            cnt0_r      <= '0;
            cnt1_r      <= '0;
            ovf_r       <= 1'b0;
            state_r     <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt0_r <= CW'(MAX_VERTS) && cnt1_r <= CW'(MAX_VERTS))
    else $error("vertex count beyond store size");

  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last) |=> !in_ready)
    else $error("input taken while a test is pending");

  a_proj_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROJ) |-> (CW'(k_r) < n_p))
    else $error("projection index beyond polygon size");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && (!out_valid_r || out_ready)) |=>
      (cnt0_r == '0 && cnt1_r == '0 && !ovf_r && out_valid_r))
    else $error("counts not cleared after result");

endmodule

// ===== dv/cpsat_verdict_check.sv =====
// Watches both channels of the SAT collision block, predicts each result word and compares it.
// Depends on cpsat_pkg, cpsat_in_if and cpsat_out_if.
module cpsat_verdict_check #(
  parameter int MAX_VERTS = 16
) (
  input  logic clk,
  input  logic rst_n,
  cpsat_in_if  in_ch,
  cpsat_out_if out_ch,
  output int   fail_count,
  output int   pending,
  output int   pairs_tested,
  output int   hits_predicted,
  output int   overflows_predicted
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic colliding;
    logic overflow;
  } verdict_t;

  // predicted result words, oldest first
  verdict_t verdict_q[$];

  // vertex stores of the pair being loaded: index 0 first polygon, 1 second
  longint vert_x [2][MAX_VERTS];
  longint vert_y [2][MAX_VERTS];
  int     vert_count [2];
  bit     dropped;

  // Strict overlap of the projected ranges on every edge normal of both polygons
  function automatic bit polygons_collide();
    longint nx, ny, dot;
    longint lo [2];
    longint hi [2];
    int j;
    if (vert_count[0] == 0 && vert_count[1] == 0) return 1'b1;
    if (vert_count[0] == 0 || vert_count[1] == 0) return 1'b0;
    for (int e = 0; e < 2; e++) begin
      for (int i = 0; i < vert_count[e]; i++) begin
        j  = (i + 1 < vert_count[e]) ? i + 1 : 0;
        nx = -(vert_y[e][j] - vert_y[e][i]);
        ny = vert_x[e][j] - vert_x[e][i];
        for (int p = 0; p < 2; p++) begin
          for (int k = 0; k < vert_count[p]; k++) begin
            dot = vert_x[p][k] * nx + vert_y[p][k] * ny;
            if (k == 0 || dot < lo[p]) lo[p] = dot;
            if (k == 0 || dot > hi[p]) hi[p] = dot;
          end
        end
        // touching ranges count as separated
        if (!(hi[1] > lo[0] && hi[0] > lo[1])) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : track
    verdict_t want;
    int poly;
    if (!rst_n) begin
      vert_count          = '{0, 0};
      dropped             = 1'b0;
      fail_count          = 0;
      pairs_tested        = 0;
      hits_predicted      = 0;
      overflows_predicted = 0;
      verdict_q.delete();
    end else begin
      // retire a result word against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          fail_count++;
          $display("%0t: result word with nothing expected: colliding=%0b overflow=%0b",
                   $time, out_ch.colliding, out_ch.overflow);
        end else begin
          want = verdict_q.pop_front();
          if (out_ch.colliding !== want.colliding) begin
            fail_count++;
            $display("%0t: colliding mismatch: expected %0b, got %0b",
                     $time, want.colliding, out_ch.colliding);
          end
          if (out_ch.overflow !== want.overflow) begin
            fail_count++;
            $display("%0t: overflow mismatch: expected %0b, got %0b",
                     $time, want.overflow, out_ch.overflow);
          end
        end
      end

      // store a vertex word; a full store drops it and flags overflow
      if (in_ch.valid && in_ch.ready) begin
        poly = (in_ch.kind == cpsat_pkg::POLY_SECOND) ? 1 : 0;
        if (vert_count[poly] < MAX_VERTS) begin
          vert_x[poly][vert_count[poly]] = longint'(in_ch.vertex_x);
          vert_y[poly][vert_count[poly]] = longint'(in_ch.vertex_y);
          vert_count[poly]++;
        end else begin
          dropped = 1'b1;
        end
        // last closes the pair: predict, then start empty
        if (in_ch.last) begin
          want.colliding = polygons_collide();
          want.overflow  = dropped;
          verdict_q = {verdict_q, want};
          pairs_tested++;
          hits_predicted      += want.colliding;
          overflows_predicted += want.overflow;
          vert_count = '{0, 0};
          dropped    = 1'b0;
        end
      end
    end
    pending = verdict_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the SAT collision testbench: clock, reset, vertex stimulus, back-pressure and verdict.
// Depends on cpsat_pkg, both channel interfaces, the block and cpsat_verdict_check.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     MAX_VERTS    = 16;
  localparam int     TARGET_WORDS = 1300;
  localparam int     LONG_HOLD    = 1500;
  localparam int     DRAIN_CYCLES = 1300;
  localparam longint LIMIT_NS     = 8_000_000;
  // cosine of k * 22.5 degrees, scaled by 1024
  localparam int UNIT_COS [16] = '{1024, 946, 724, 392, 0, -392, -724, -946,
                                   -1024, -946, -724, -392, 0, 392, 724, 946};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int in_idle_pct  = 23;
  int out_idle_pct = 75;
  int hold_ticket  = 0;
  int words_sent   = 0;

  int fail_count, pending, pairs_tested, hits_predicted, overflows_predicted;

  // vertices of the next pair, per polygon
  int first_x[$], first_y[$], second_x[$], second_y[$];

  always #5 clk = ~clk;

  cpsat_in_if  in_ch();
  cpsat_out_if out_ch();

  convex_polygon_sat_collision #(
    .MAX_VERTS  (MAX_VERTS),
    .COORD_BITS (16)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cpsat_verdict_check #(
    .MAX_VERTS (MAX_VERTS)
  ) verdict_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_ch               (in_ch),
    .out_ch              (out_ch),
    .fail_count          (fail_count),
    .pending             (pending),
    .pairs_tested        (pairs_tested),
    .hits_predicted      (hits_predicted),
    .overflows_predicted (overflows_predicted)
  );

  // Hard stop for a hung run
  initial begin : watchdog
    #(LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold per ticket
  initial begin : result_side
    int seen_ticket;
    int hold_left;
    seen_ticket   = 0;
    hold_left     = 0;
    out_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ticket != seen_ticket) begin
        seen_ticket = hold_ticket;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Offer one vertex word and hold it until taken; enter and leave at a falling edge
  task automatic put_vertex(input logic kind, input int x, input int y, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.kind     = kind;
    in_ch.vertex_x = x[15:0];
    in_ch.vertex_y = y[15:0];
    in_ch.last     = last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic push_vertex(input bit second, input int x, input int y);
    if (second) begin
      second_x = {second_x, x};
      second_y = {second_y, y};
    end else begin
      first_x = {first_x, x};
      first_y = {first_y, y};
    end
  endtask

  // Convex shape: n points on a circle in angular order; past the store size, spill noise
  task automatic add_shape(input bit second, input int n, input int cx, input int cy,
                           input int r);
    int rot, need, k, d, x, y;
    bit flip;
    rot  = $urandom_range(15);
    flip = 1'($urandom_range(1));
    need = n;
    for (k = 0; k < 16 && need > 0; k++) begin
      if ($urandom_range(15 - k) < need) begin
        d = flip ? ((rot - k) & 15) : ((rot + k) & 15);
        x = cx + UNIT_COS[d] * r / 1024;
        y = cy + UNIT_COS[(d + 12) & 15] * r / 1024;
        push_vertex(second, x, y);
        need--;
        // now and then repeat a vertex to make a zero-length edge
        if ($urandom_range(39) == 0) push_vertex(second, x, y);
      end
    end
    for (k = 0; k < need; k++) begin
      push_vertex(second, $urandom_range(65535), $urandom_range(65535));
    end
  endtask

  // Interleave both polygons at random, keeping each one's order; last on the final word
  task automatic send_pair();
    int ia, ib, left;
    bit take_second;
    ia   = 0;
    ib   = 0;
    left = first_x.size() + second_x.size();
    while (left > 0) begin
      if (ia == first_x.size()) take_second = 1'b1;
      else if (ib == second_x.size()) take_second = 1'b0;
      else take_second = 1'($urandom_range(1));
      if (take_second) begin
        put_vertex(cpsat_pkg::POLY_SECOND, second_x[ib], second_y[ib], left == 1);
        ib++;
      end else begin
        put_vertex(cpsat_pkg::POLY_FIRST, first_x[ia], first_y[ia], left == 1);
        ia++;
      end
      left--;
    end
    first_x.delete();
    first_y.delete();
    second_x.delete();
    second_y.delete();
  endtask

  // Mostly small polygons, a few full stores and a few past the store size
  function automatic int pick_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return $urandom_range(17, 19);
    if (roll < 7) return MAX_VERTS;
    return $urandom_range(1, 6);
  endfunction

  task automatic random_pair();
    int s, ca_x, ca_y, n;
    if ($urandom_range(99) < 12) begin
      // scattered words: any kind, full coordinate range
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        push_vertex(1'($urandom_range(1)), $urandom_range(65535), $urandom_range(65535));
      end
    end else begin
      case ($urandom_range(3))
        0:       s = 60;
        1:       s = 600;
        2:       s = 6000;
        default: s = 10000;
      endcase
      // keep both shapes inside the coordinate range
      ca_x = int'($urandom_range(64000 - 6 * s)) - (32000 - 3 * s);
      ca_y = int'($urandom_range(64000 - 6 * s)) - (32000 - 3 * s);
      add_shape(1'b0, pick_size(), ca_x, ca_y, $urandom_range(s, s / 4));
      n = ($urandom_range(99) < 3) ? 0 : pick_size();
      add_shape(1'b1, n, ca_x + int'($urandom_range(4 * s)) - 2 * s,
                ca_y + int'($urandom_range(4 * s)) - 2 * s, $urandom_range(s, s / 4));
    end
    send_pair();
  endtask

  initial begin : stimulus
    int phase, want_phase;
    in_ch.valid    = 1'b0;
    in_ch.kind     = cpsat_pkg::POLY_FIRST;
    in_ch.vertex_x = '0;
    in_ch.vertex_y = '0;
    in_ch.last     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // lone vertex of the second polygon, first polygon empty
    put_vertex(cpsat_pkg::POLY_SECOND, 0, 0, 1'b1);
    // overlapping triangles, interleaved
    put_vertex(cpsat_pkg::POLY_FIRST, 0, 0, 1'b0);
    put_vertex(cpsat_pkg::POLY_SECOND, 64, 64, 1'b0);
    put_vertex(cpsat_pkg::POLY_FIRST, 256, 0, 1'b0);
    put_vertex(cpsat_pkg::POLY_SECOND, 320, 64, 1'b0);
    put_vertex(cpsat_pkg::POLY_FIRST, 0, 256, 1'b0);
    put_vertex(cpsat_pkg::POLY_SECOND, 64, 320, 1'b1);
    // triangles sharing an edge: ranges only touch
    put_vertex(cpsat_pkg::POLY_FIRST, 0, 0, 1'b0);
    put_vertex(cpsat_pkg::POLY_FIRST, 32, 0, 1'b0);
    put_vertex(cpsat_pkg::POLY_FIRST, 0, 32, 1'b0);
    put_vertex(cpsat_pkg::POLY_SECOND, 32, 0, 1'b0);
    put_vertex(cpsat_pkg::POLY_SECOND, 32, 32, 1'b0);
    put_vertex(cpsat_pkg::POLY_SECOND, 0, 32, 1'b1);
    // full-scale triangle around a small one
    put_vertex(cpsat_pkg::POLY_FIRST, -32768, -32768, 1'b0);
    put_vertex(cpsat_pkg::POLY_FIRST, 32767, -32768, 1'b0);
    put_vertex(cpsat_pkg::POLY_FIRST, 0, 32767, 1'b0);
    put_vertex(cpsat_pkg::POLY_SECOND, -16, -16, 1'b0);
    put_vertex(cpsat_pkg::POLY_SECOND, 16, -16, 1'b0);
    put_vertex(cpsat_pkg::POLY_SECOND, 0, 16, 1'b1);
    // repeated vertex gives a zero-length edge
    put_vertex(cpsat_pkg::POLY_FIRST, 48, 48, 1'b0);
    put_vertex(cpsat_pkg::POLY_FIRST, 48, 48, 1'b0);
    put_vertex(cpsat_pkg::POLY_FIRST, 96, 80, 1'b0);
    put_vertex(cpsat_pkg::POLY_SECOND, 60, 52, 1'b1);

    // full store, the word with last is the one dropped
    add_shape(1'b0, MAX_VERTS + 1, 0, 0, 800);
    send_pair();

    // random pairs in three idling phases
    phase = 0;
    while (words_sent < TARGET_WORDS) begin
      want_phase = words_sent * 3 / TARGET_WORDS;
      if (want_phase != phase) begin
        // stop offering until every result is back
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        phase = want_phase;
        if (phase == 1) begin
          in_idle_pct  = 75;
          out_idle_pct <= 23;
        end else begin
          in_idle_pct  = 0;
          out_idle_pct <= 0;
          // long receiver hold while words keep coming
          hold_ticket  <= hold_ticket + 1;
        end
      end
      random_pair();
    end

    // drain, then watch for stray results
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d vertex words in %0d polygon pairs under three idling mixes.",
             words_sent, pairs_tested);
    $display("Predicted %0d colliding pairs and %0d pairs with a full vertex store.",
             hits_predicted, overflows_predicted);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
